>>> src/htt_pkg.sv
// ----------------------------------------------------------------------------
// htt_pkg
// Shared types, constants and helpers for the heartbeat timeout table.
// ----------------------------------------------------------------------------
`default_nettype none

package htt_pkg;

  localparam int MAX_PEERS = 16;
  localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int PEER_W    = 16;
  localparam int MISS_W    = 8;
  localparam int LIMIT_W   = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(5);
  localparam logic [MISS_W-1:0]  MISS_MAX  = '1;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // result queue at the output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_REG  = 2'd0,
    OP_UPD  = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_OK        = 3'd0,
    EV_FULL      = 3'd1,
    EV_UNKNOWN   = 3'd2,
    EV_TIMEOUT   = 3'd3,
    EV_HEARTBEAT = 3'd4,
    EV_NONE      = 3'd5
  } ev_kind_t;

  typedef struct packed {
    op_t               op;
    logic [PEER_W-1:0] peer;
  } cmd_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [PEER_W-1:0] peer;
    logic              last;
  } res_t;

  // lowest set bit of a slot vector
  function automatic idx_t first_idx(input logic [MAX_PEERS-1:0] v);
    idx_t r;
    r = '0;
    for (int k = MAX_PEERS - 1; k >= 0; k--) begin
      if (v[k]) r = idx_t'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/heartbeat_timeout_table_unit.sv
// ----------------------------------------------------------------------------
// heartbeat_timeout_table_unit
// Keepalive monitor over a table of peer slots with missed-heartbeat counts.
// ----------------------------------------------------------------------------
// Items enter a two-deep command queue and are carried out by a sequencer
// that owns the slot table; results leave through a four-deep result queue.
// A tick on an empty table returns a single none result; otherwise the
// sequencer walks the slots one per cycle, first for timeouts and then,
// unless every live peer times out, for heartbeat requests. A full result
// queue stalls the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_timeout_table_unit
  import htt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output      logic               in_full,
  input  wire logic [1:0]         in_op,
  input  wire logic [PEER_W-1:0]  in_peer_id,
  output      logic               out_empty,
  input  wire logic               out_pop,
  output      logic [2:0]         out_event_kind,
  output      logic [PEER_W-1:0]  out_event_peer,
  output      logic               out_last,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0] limit_r;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic               res_push;
  logic               res_full;
  res_t               res;
  res_t               head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  htt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_peer_id(in_peer_id),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  htt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .attempt_limit(limit_r),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res)
  );

  htt_out_q u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (out_pop),
    .empty(out_empty),
    .dout (head)
  );

  assign out_event_kind = head.kind;
  assign out_event_peer = head.peer;
  assign out_last       = head.last;

endmodule

`default_nettype wire

>>> src/htt_front.sv
// ----------------------------------------------------------------------------
// htt_front
// Input side: accepts items, drops unused op codes, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_front
  import htt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output      logic              in_full,
  input  wire logic [1:0]        in_op,
  input  wire logic [PEER_W-1:0] in_peer_id,
  output      logic              cmd_valid,
  output      cmd_t              cmd,
  input  wire logic              cmd_pop
);

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_r, wr_nxt;
  logic [CQ_AW-1:0] rd_r, rd_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             acc;
  logic             enq;
  logic             deq;
  op_t              op;

  assign op        = op_t'(in_op);
  assign in_full   = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign acc       = in_push && !in_full;
  assign enq       = acc && (op != OP_NOP);
  assign cmd_valid = (cnt_r != '0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_r];

  always_comb begin
    wr_nxt  = enq ? wr_r + 1'b1 : wr_r;
    rd_nxt  = deq ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (enq && !deq) cnt_nxt = cnt_r + 1'b1;
    else if (!enq && deq) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_r] <= '{op: op, peer: in_peer_id};
    end
  end

endmodule

`default_nettype wire

>>> src/htt_back.sv
// ----------------------------------------------------------------------------
// htt_back
// Slot table and sequencer: lookups, registration and the tick walk.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_back
  import htt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output      logic               cmd_pop,
  input  wire logic [LIMIT_W-1:0] attempt_limit,
  input  wire logic               res_full,
  output      logic               res_push,
  output      res_t               res
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_SCAN = 3'b010,
    BK_BEAT = 3'b100
  } bk_state_t;

  bk_state_t          state_r, state_nxt;
  logic [MAX_PEERS-1:0] valid_r, valid_nxt;
  logic [MAX_PEERS-1:0] to_r, to_nxt;
  logic [PEER_W-1:0]  peer_r [MAX_PEERS];
  logic [PEER_W-1:0]  peer_nxt [MAX_PEERS];
  logic [MISS_W-1:0]  miss_r [MAX_PEERS];
  logic [MISS_W-1:0]  miss_nxt [MAX_PEERS];
  idx_t               idx_r, idx_nxt;

  logic [MAX_PEERS-1:0] match_vec;
  logic [MAX_PEERS-1:0] over_vec;
  logic [MAX_PEERS-1:0] surv;
  logic [MAX_PEERS-1:0] to_above;
  logic [MAX_PEERS-1:0] live_above;
  idx_t               hit_idx;
  idx_t               free_idx;
  logic               hit;
  logic               has_free;
  logic               at_end;

  always_comb begin
    for (int j = 0; j < MAX_PEERS; j++) begin
      match_vec[j] = valid_r[j] && (peer_r[j] == cmd.peer);
      over_vec[j]  = valid_r[j] && (miss_r[j] >= attempt_limit);
    end
  end

  assign hit        = |match_vec;
  assign has_free   = ~&valid_r;
  assign hit_idx    = first_idx(match_vec);
  assign free_idx   = first_idx(~valid_r);
  assign surv       = valid_r & ~to_r;
  assign to_above   = (to_r >> idx_r) >> 1;
  assign live_above = (valid_r >> idx_r) >> 1;
  assign at_end     = (idx_r == idx_t'(MAX_PEERS - 1));

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    to_nxt    = to_r;
    peer_nxt  = peer_r;
    miss_nxt  = miss_r;
    idx_nxt   = idx_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '{kind: EV_OK, peer: cmd.peer, last: 1'b1};

    unique case (state_r)
      BK_IDLE: begin
        // pop only with room for the single-result cases
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_REG: begin
              res_push = 1'b1;
              if (hit) begin
                miss_nxt[hit_idx] = '0;
              end else if (has_free) begin
                valid_nxt[free_idx] = 1'b1;
                peer_nxt[free_idx]  = cmd.peer;
                miss_nxt[free_idx]  = '0;
              end else begin
                res.kind = EV_FULL;
                res.peer = '0;
              end
            end
            OP_UPD: begin
              res_push = 1'b1;
              if (hit) begin
                miss_nxt[hit_idx] = '0;
              end else begin
                res.kind = EV_UNKNOWN;
              end
            end
            OP_TICK: begin
              if (valid_r == '0) begin
                res_push = 1'b1;
                res.kind = EV_NONE;
                res.peer = '0;
              end else begin
                to_nxt    = over_vec;
                idx_nxt   = '0;
                state_nxt = BK_SCAN;
              end
            end
            OP_NOP: begin
            end
          endcase
        end
      end

      BK_SCAN: begin
        res.kind = EV_TIMEOUT;
        res.peer = peer_r[idx_r];
        res.last = (surv == '0) && (to_above == '0);
        if (!(to_r[idx_r] && res_full)) begin
          if (to_r[idx_r]) begin
            res_push          = 1'b1;
            valid_nxt[idx_r]  = 1'b0;
          end else if (valid_r[idx_r] && miss_r[idx_r] != MISS_MAX) begin
            miss_nxt[idx_r] = miss_r[idx_r] + 1'b1;
          end
          if (at_end) begin
            idx_nxt   = '0;
            state_nxt = (surv == '0) ? BK_IDLE : BK_BEAT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      BK_BEAT: begin
        res.kind = EV_HEARTBEAT;
        res.peer = peer_r[idx_r];
        res.last = (live_above == '0);
        if (!(valid_r[idx_r] && res_full)) begin
          res_push = valid_r[idx_r];
          if (at_end) begin
            idx_nxt   = '0;
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= '0;
      to_r    <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      to_r    <= to_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    peer_r <= peer_nxt;
    miss_r <= miss_nxt;
  end

endmodule

`default_nettype wire

>>> src/htt_out_q.sv
// ----------------------------------------------------------------------------
// htt_out_q
// Result queue; decouples the sequencer from the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module htt_out_q
  import htt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t din,
  output      logic full,
  input  wire logic pop,
  output      logic empty,
  output      res_t dout
);

  res_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_r, wr_nxt;
  logic [OQ_AW-1:0] rd_r, rd_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             enq;
  logic             deq;

  assign full  = (cnt_r == OQ_CW'(OQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign enq   = push && !full;
  assign deq   = pop && !empty;
  assign dout  = q_r[rd_r];

  always_comb begin
    wr_nxt  = enq ? wr_r + 1'b1 : wr_r;
    rd_nxt  = deq ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (enq && !deq) cnt_nxt = cnt_r + 1'b1;
    else if (!enq && deq) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_r] <= din;
    end
  end

endmodule

`default_nettype wire
